>>> hdl/cber_pkg.sv
// Shared constants and types for the example replacement block.
`default_nettype none
package cber_pkg;
    localparam int NumSlots = 32;
    localparam int IdxW     = $clog2(NumSlots);
    localparam int FillW    = IdxW + 1;
    localparam int ConfW    = 32;
    localparam int ScoreW   = ConfW + 1;
    localparam int OrderW   = 32;
    localparam int EntryW   = ScoreW + OrderW;

    localparam logic [1:0] ActAppend  = 2'd0;
    localparam logic [1:0] ActReplace = 2'd1;
    localparam logic [1:0] ActNone    = 2'd2;

    localparam logic [1:0] RegTarget   = 2'd0;
    localparam logic [1:0] RegKeep     = 2'd1;
    localparam logic [1:0] RegCapacity = 2'd2;

    localparam logic KindStored    = 1'b0;
    localparam logic KindCandidate = 1'b1;

    typedef struct packed {
        logic [OrderW-1:0]        order;
        logic signed [ScoreW-1:0] score;
    } entry_t;
endpackage
`default_nettype wire

>>> hdl/confidence_based_example_replacement.sv
// Example replacement: loads slot and candidate scores and picks placements at batch end.
// While loading, a score transaction is taken whenever one is offered. On the transaction
// marked tlast the block stops taking input and runs selection: every placement costs one
// full scan of the two 32-entry score memories (one read port each): all 32 addresses are
// read in turn, the compare pipeline empties and one decide step follows, held longer
// while the output register is stalled. One more scan ends the batch before input is
// taken again. Result transactions leave through an output register.
`default_nettype none
module confidence_based_example_replacement
    import cber_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [4:0] item_index, [5] predicted_positive, [37:6] confidence, [39:38] zero
    input  wire logic [39:0] s_axis_tdata,
    // [0] kind
    input  wire logic        s_axis_tuser,
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [4:0] slot, [9:5] candidate, [15:10] zero
    output logic      [15:0] m_axis_tdata,
    // [1:0] action
    output logic      [1:0]  m_axis_tuser,
    output logic             m_axis_tlast
);
    typedef enum logic [1:0] {S_LOAD, S_SCAN, S_LAST, S_DECIDE} state_t;

    state_t state_reg;
    logic              target_reg;
    logic [FillW-1:0]  keep_reg, cap_reg, filled_reg, start_reg, cap_eff;
    logic [OrderW-1:0] arrival_reg;
    logic [NumSlots-1:0] s_valid_reg, c_valid_reg, s_used_reg, c_used_reg;
    entry_t smem [NumSlots];
    entry_t cmem [NumSlots];
    entry_t s_rdata_reg, c_rdata_reg, s_best_reg, c_best_reg, new_entry;
    logic [IdxW-1:0] scan_addr_reg, cmp_idx_reg, s_best_idx_reg, c_best_idx_reg;
    logic cmp_vld_reg, s_found_reg, c_found_reg;
    logic pend_vld_reg;
    logic [1:0] pend_act_reg;
    logic [IdxW-1:0] pend_slot_reg, pend_cand_reg;
    logic out_vld_reg, out_last_reg;
    logic [1:0] out_act_reg;
    logic [IdxW-1:0] out_slot_reg, out_cand_reg;

    logic in_acc, cfg_wr, out_free, out_load, appendable, cont;
    logic c_elig, s_elig, c_better, s_better;
    logic [IdxW-1:0] in_idx;
    logic signed [ScoreW-1:0] conf_ext;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    always_comb
    begin
        case (paddr[3:2])
            RegTarget:   prdata = {31'd0, target_reg};
            RegKeep:     prdata = {26'd0, keep_reg};
            RegCapacity: prdata = {26'd0, cap_reg};
            default:     prdata = 32'd0;
        endcase
    end

    assign s_axis_tready = (state_reg == S_LOAD);
    assign in_acc   = s_axis_tvalid & s_axis_tready;
    assign in_idx   = s_axis_tdata[IdxW-1:0];
    assign conf_ext = ScoreW'($signed(s_axis_tdata[37:6]));
    assign new_entry.order = arrival_reg;
    assign new_entry.score = (s_axis_tdata[5] != target_reg) ? -conf_ext : conf_ext;

    assign cap_eff = (cap_reg == '0) ? FillW'(1) :
                     (cap_reg > FillW'(NumSlots)) ? FillW'(NumSlots) : cap_reg;
    assign appendable = filled_reg < cap_eff;
    assign cont = c_found_reg &&
                  (appendable || (s_found_reg && (c_best_reg.score < s_best_reg.score)));
    assign out_free = !out_vld_reg || m_axis_tready;
    assign out_load = (state_reg == S_DECIDE) && out_free && (!cont || pend_vld_reg);

    assign c_elig = c_valid_reg[cmp_idx_reg] && !c_used_reg[cmp_idx_reg];
    assign s_elig = s_valid_reg[cmp_idx_reg] && !s_used_reg[cmp_idx_reg] &&
                    ({1'b0, cmp_idx_reg} >= keep_reg) && ({1'b0, cmp_idx_reg} < start_reg);
    assign c_better = !c_found_reg || (c_rdata_reg.score < c_best_reg.score) ||
                      ((c_rdata_reg.score == c_best_reg.score) &&
                       (c_rdata_reg.order < c_best_reg.order));
    assign s_better = !s_found_reg || (s_rdata_reg.score > s_best_reg.score) ||
                      ((s_rdata_reg.score == s_best_reg.score) &&
                       (s_rdata_reg.order < s_best_reg.order));

    always_ff @(posedge clk)
    begin
        if (in_acc && s_axis_tuser == KindStored)
        begin
            smem[in_idx] <= new_entry;
        end
        if (in_acc && s_axis_tuser == KindCandidate)
        begin
            cmem[in_idx] <= new_entry;
        end
        s_rdata_reg <= smem[scan_addr_reg];
        c_rdata_reg <= cmem[scan_addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            target_reg    <= 1'b1;
            keep_reg      <= FillW'(1);
            cap_reg       <= FillW'(NumSlots);
            filled_reg    <= '0;
            start_reg     <= '0;
            arrival_reg   <= '0;
            s_valid_reg   <= '0;
            c_valid_reg   <= '0;
            s_used_reg    <= '0;
            c_used_reg    <= '0;
            scan_addr_reg <= '0;
            cmp_vld_reg   <= 1'b0;
            s_found_reg   <= 1'b0;
            c_found_reg   <= 1'b0;
            pend_vld_reg  <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (paddr[3:2])
                    RegTarget:   target_reg <= pwdata[0];
                    RegKeep:     keep_reg   <= pwdata[FillW-1:0];
                    RegCapacity: cap_reg    <= pwdata[FillW-1:0];
                    default:     ;
                endcase
            end
            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_vld_reg <= 1'b0;
            end
            cmp_vld_reg <= (state_reg == S_SCAN);
            if (cmp_vld_reg && c_elig && c_better)
            begin
                c_found_reg    <= 1'b1;
                c_best_reg     <= c_rdata_reg;
                c_best_idx_reg <= cmp_idx_reg;
            end
            if (cmp_vld_reg && s_elig && s_better)
            begin
                s_found_reg    <= 1'b1;
                s_best_reg     <= s_rdata_reg;
                s_best_idx_reg <= cmp_idx_reg;
            end
            case (state_reg)
                S_LOAD:
                begin
                    if (in_acc)
                    begin
                        if (s_axis_tuser == KindStored)
                        begin
                            s_valid_reg[in_idx] <= 1'b1;
                        end
                        else
                        begin
                            c_valid_reg[in_idx] <= 1'b1;
                        end
                        if (arrival_reg != '1)
                        begin
                            arrival_reg <= arrival_reg + OrderW'(1);
                        end
                        if (s_axis_tlast)
                        begin
                            start_reg     <= filled_reg;
                            scan_addr_reg <= '0;
                            s_found_reg   <= 1'b0;
                            c_found_reg   <= 1'b0;
                            state_reg     <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    cmp_idx_reg <= scan_addr_reg;
                    if (scan_addr_reg == IdxW'(NumSlots - 1))
                    begin
                        state_reg <= S_LAST;
                    end
                    else
                    begin
                        scan_addr_reg <= scan_addr_reg + IdxW'(1);
                    end
                end
                S_LAST:
                begin
                    if (!cmp_vld_reg)
                    begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    if (out_free)
                    begin
                        if (cont)
                        begin
                            if (pend_vld_reg)
                            begin
                                out_act_reg  <= pend_act_reg;
                                out_slot_reg <= pend_slot_reg;
                                out_cand_reg <= pend_cand_reg;
                                out_last_reg <= 1'b0;
                            end
                            pend_vld_reg  <= 1'b1;
                            pend_cand_reg <= c_best_idx_reg;
                            c_used_reg[c_best_idx_reg] <= 1'b1;
                            if (appendable)
                            begin
                                pend_act_reg  <= ActAppend;
                                pend_slot_reg <= filled_reg[IdxW-1:0];
                                filled_reg    <= filled_reg + FillW'(1);
                            end
                            else
                            begin
                                pend_act_reg  <= ActReplace;
                                pend_slot_reg <= s_best_idx_reg;
                                s_used_reg[s_best_idx_reg] <= 1'b1;
                            end
                            scan_addr_reg <= '0;
                            s_found_reg   <= 1'b0;
                            c_found_reg   <= 1'b0;
                            state_reg     <= S_SCAN;
                        end
                        else
                        begin
                            out_last_reg <= 1'b1;
                            out_act_reg  <= pend_vld_reg ? pend_act_reg : ActNone;
                            out_slot_reg <= pend_vld_reg ? pend_slot_reg : '0;
                            out_cand_reg <= pend_vld_reg ? pend_cand_reg : '0;
                            pend_vld_reg <= 1'b0;
                            s_valid_reg  <= '0;
                            c_valid_reg  <= '0;
                            s_used_reg   <= '0;
                            c_used_reg   <= '0;
                            arrival_reg  <= '0;
                            state_reg    <= S_LOAD;
                        end
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {6'd0, out_cand_reg, out_slot_reg};
    assign m_axis_tuser  = out_act_reg;
    assign m_axis_tlast  = out_last_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg <= FillW'(NumSlots))
        else $error("fill level beyond store size");
    a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == ActNone) |-> m_axis_tlast)
        else $error("empty result not final");
    a_used_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ((c_used_reg & ~c_valid_reg) == '0) && ((s_used_reg & ~s_valid_reg) == '0))
        else $error("used entry without score");
    a_load_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |-> (!pend_vld_reg && c_used_reg == '0))
        else $error("selection state left over");
endmodule
`default_nettype wire
